// File: src/assert_macros.svh
// Assertion macros used by the checker file frsc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: src/frsc_pkg.sv
// Package for the frame receiver: field widths, frame marker bytes and status codes.
// No dependencies.
package frsc_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] START_MARK = 8'h0F;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'hF0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

// File: src/frsc_if.sv
// Valid/ready channels: received bytes in, frame results out.
// Depends on frsc_pkg.
interface frsc_byte_if import frsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frsc_result_if import frsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] frame_length;

  modport source (output valid, output status, output frame_length, input ready);
  modport sink (input valid, input status, input frame_length, output ready);
endinterface

// File: src/frame_receiver_sum_check.sv
// Byte-stream frame receiver with an 8-bit sum check.
// Depends on frsc_pkg and the channel interfaces in frsc_if.sv.
//
// Channels: rx takes one received byte per transaction; result gives one
// frame result per transaction (status 0 ok / 1 fail, and the length byte).
// A frame is start 0x0F, length L, then L-1 more counted bytes, then the
// end byte. Bytes outside a frame are dropped. A zero length fails at once.
// Throughput: one byte per cycle while rx.ready is high; the count and sum
// update is a single add-and-compare between the state registers.
// Result path: the result for the byte that closes the frame is registered
// in the output register, or in the skid register while the output is held.
// Stall: results queue in an output register plus one skid register, so
// rx.ready stays high while one result waits; it drops only when both
// are full, and comes straight from a register.
// Reset: synchronous, clears the frame state and empties both result
// registers; rx.ready is high in the first cycle after reset.
module frame_receiver_sum_check import frsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  frsc_byte_if.sink    rx,
  frsc_result_if.source result
);

  logic              in_frame, in_frame_next;
  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0] frame_len, frame_len_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  logic              res_valid;
  logic              res_status;
  logic [BYTE_W-1:0] res_len;

  logic              out_valid, skid_valid;
  logic              out_status, skid_status;
  logic [BYTE_W-1:0] out_len, skid_len;

  logic accept, pop;

  assign rx.ready = !skid_valid;
  assign accept   = rx.valid && rx.ready;
  assign pop      = out_valid && result.ready;

  always_comb begin
    in_frame_next    = in_frame;
    byte_count_next  = byte_count;
    frame_len_next   = frame_len;
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    res_status       = STATUS_FAIL;
    res_len          = frame_len;
    if (accept) begin
      if (!in_frame) begin
        if (rx.rx_byte == START_MARK) begin
          in_frame_next    = 1'b1;
          byte_count_next  = '0;
          running_sum_next = '0;
          frame_len_next   = '0;
        end
      end else if (byte_count == '0) begin
        frame_len_next   = rx.rx_byte;
        running_sum_next = rx.rx_byte;
        byte_count_next  = BYTE_W'(1);
        if (rx.rx_byte == '0) begin
          res_valid        = 1'b1;
          res_status       = STATUS_FAIL;
          res_len          = '0;
          in_frame_next    = 1'b0;
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      end else if (byte_count == frame_len) begin
        res_valid        = 1'b1;
        res_status       = ((rx.rx_byte == END_MARK) && (running_sum == '0)) ?
                           STATUS_OK : STATUS_FAIL;
        res_len          = frame_len;
        in_frame_next    = 1'b0;
        byte_count_next  = '0;
        running_sum_next = '0;
      end else begin
        running_sum_next = running_sum + rx.rx_byte;
        byte_count_next  = byte_count + BYTE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      frame_len   <= '0;
      running_sum <= '0;
    end else begin
      in_frame    <= in_frame_next;
      byte_count  <= byte_count_next;
      frame_len   <= frame_len_next;
      running_sum <= running_sum_next;
    end
  end

  // output register with one skid entry; skid only fills while out is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid   <= 1'b1;
        out_status  <= skid_status;
        out_len     <= skid_len;
        skid_valid  <= 1'b0;
      end else begin
        out_valid   <= res_valid;
        out_status  <= res_status;
        out_len     <= res_len;
      end
    end else if (res_valid) begin
      skid_valid  <= 1'b1;
      skid_status <= res_status;
      skid_len    <= res_len;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.frame_length = out_len;

endmodule

// File: src/frsc_checker.sv
// Port-level checks for frame_receiver_sum_check, attached by bind.
// Depends on frsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frsc_checker import frsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rx_valid,
  input logic              rx_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_status,
  input logic [BYTE_W-1:0] res_length
);

  logic rx_take;
  assign rx_take = rx_valid && rx_ready;

  // nothing pending straight after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !res_valid && rx_ready)
  // back-pressure only once a result is already waiting
  `ASSERT_SAME(a_ready_low_needs_result, clk, rst, !rx_ready, res_valid)
  // a new result appears only after a byte was taken
  `ASSERT_SAME(a_result_from_byte, clk, rst, $rose(res_valid), $past(rx_take))
  // a stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_status) && $stable(res_length))

endmodule

bind frame_receiver_sum_check frsc_checker u_frsc_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx.valid),
  .rx_ready   (rx.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_length (result.frame_length)
);

// File: bench/tb_frame_receiver_sum_check.sv
// Testbench for frame_receiver_sum_check: directed and random byte streams,
// with results checked against an in-bench deframer and sum predictor.
// Depends on frsc_pkg, the channel interfaces in frsc_if.sv and the RTL top.
module tb_frame_receiver_sum_check;
  timeunit 1ns;
  timeprecision 1ps;
  import frsc_pkg::*;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] frame_length;
  } frame_verdict_t;

  localparam int RANDOM_FRAME_BYTES = 1900;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int HOLDOFF_AT         = 600;
  localparam int HOLDOFF_CYCLES     = 400;
  localparam int MAX_REPORTS        = 10;

  // idle noise, zero length, length one, good frame, start byte inside a
  // frame, bad end byte, bad sum
  localparam logic [BYTE_W-1:0] DIRECTED_BYTES [25] = '{
    8'h00, 8'hFF, END_MARK,
    START_MARK, 8'h00,
    START_MARK, 8'h01, END_MARK,
    START_MARK, 8'h02, 8'hFE, END_MARK,
    START_MARK, 8'h03, START_MARK, 8'hEE, END_MARK,
    START_MARK, 8'h02, 8'hFE, 8'h55,
    START_MARK, 8'h02, 8'h00, END_MARK
  };

  logic clk;
  logic rst = 1'b1;

  frsc_byte_if   rx_ch ();
  frsc_result_if res_ch ();

  frame_receiver_sum_check u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  logic [BYTE_W-1:0] pending_bytes [$];
  frame_verdict_t    expected_verdicts [$];
  int                frame_bytes_queued = 0;
  int                total_bytes = 0;
  int                bytes_taken = 0;
  int                error_count = 0;
  logic              rx_taken = 1'b0;

  // predictor state
  logic              pr_in_frame = 1'b0;
  logic [BYTE_W-1:0] pr_count = '0;
  logic [BYTE_W-1:0] pr_len = '0;
  logic [BYTE_W-1:0] pr_sum = '0;

  task automatic advance_deframer(input logic [BYTE_W-1:0] b);
    frame_verdict_t v;
    if (!pr_in_frame) begin
      if (b == START_MARK) begin
        pr_in_frame = 1'b1;
        pr_count = '0;
        pr_sum = '0;
        pr_len = '0;
      end
    end else if (pr_count == '0) begin
      pr_len = b;
      pr_sum = b;
      pr_count = 8'd1;
      if (b == 8'd0) begin
        v.status = STATUS_FAIL;
        v.frame_length = 8'd0;
        expected_verdicts.push_back(v);
        pr_in_frame = 1'b0;
        pr_count = '0;
        pr_sum = '0;
      end
    end else if (pr_count == pr_len) begin
      v.status = (b == END_MARK && pr_sum == '0) ? STATUS_OK : STATUS_FAIL;
      v.frame_length = pr_len;
      expected_verdicts.push_back(v);
      pr_in_frame = 1'b0;
      pr_count = '0;
      pr_sum = '0;
    end else begin
      pr_sum = pr_sum + b;
      pr_count = pr_count + 8'd1;
    end
  endtask

  task automatic push_frame_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    frame_bytes_queued++;
  endtask

  // Mostly well-formed frames with random content; some carry a bad check,
  // a bad end byte, or are cut short.
  task automatic append_frame();
    int unsigned       len_sel, flaw, cut, n;
    logic [BYTE_W-1:0] len_b, sum, b;
    len_sel = $urandom_range(0, 99);
    if (len_sel < 3) len_b = 8'd0;
    else if (len_sel < 5) len_b = 8'd255;
    else if (len_sel < 9) len_b = 8'($urandom_range(13, 254));
    else len_b = 8'($urandom_range(1, 12));
    flaw = $urandom_range(0, 99);
    cut = $urandom_range(2, int'(len_b) + 1);
    push_frame_byte(START_MARK);
    push_frame_byte(len_b);
    sum = len_b;
    if (len_b == 8'd0) return;
    for (n = 2; n <= len_b; n++) begin
      if (flaw >= 88 && flaw < 94 && n == cut) return;
      if (n == len_b) begin
        b = 8'd0 - sum;
        if (flaw >= 70 && flaw < 80) b = b + 8'($urandom_range(1, 255));
      end else begin
        case ($urandom_range(0, 9))
          0: b = START_MARK;
          1: b = END_MARK;
          default: b = 8'($urandom_range(0, 255));
        endcase
      end
      sum = sum + b;
      push_frame_byte(b);
    end
    if (flaw >= 88 && flaw < 94) return;
    if (flaw >= 80 && flaw < 88) begin
      b = 8'($urandom_range(0, 255));
      if (b == END_MARK) b = ~b;
      push_frame_byte(b);
    end else begin
      push_frame_byte(END_MARK);
    end
  endtask

  task automatic append_noise();
    int unsigned       k, count;
    logic [BYTE_W-1:0] b;
    count = $urandom_range(1, 3);
    for (k = 0; k < count; k++) begin
      b = 8'($urandom_range(0, 255));
      if (b == START_MARK) b = ~b;
      pending_bytes.push_back(b);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!rx_ch.valid || rx_taken) begin
      if (gap_left > 0) begin
        rx_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() == 0) begin
        rx_ch.valid <= 1'b0;
      end else begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= pending_bytes.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(100, 300);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall mode changes per epoch, plus one long hold-off
  int   epoch_left = 0;
  int   stall_mode = 0;
  int   holdoff_left = 0;
  logic holdoff_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      res_ch.ready <= 1'b0;
      holdoff_left--;
    end else if (!holdoff_done && bytes_taken >= HOLDOFF_AT) begin
      res_ch.ready <= 1'b0;
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
    end else begin
      if (epoch_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        epoch_left = $urandom_range(16, 200);
      end
      epoch_left--;
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    frame_verdict_t want;
    if (rst) begin
      rx_taken <= 1'b0;
      pr_in_frame = 1'b0;
      pr_count = '0;
      pr_len = '0;
      pr_sum = '0;
    end else begin
      rx_taken <= rx_ch.valid && rx_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: status %0d length %0d",
                     res_ch.status, res_ch.frame_length);
        end else begin
          want = expected_verdicts.pop_front();
          if (res_ch.status !== want.status ||
              res_ch.frame_length !== want.frame_length) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("result mismatch: status exp %0d got %0d, length exp %0d got %0d",
                       want.status, res_ch.status, want.frame_length,
                       res_ch.frame_length);
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        advance_deframer(rx_ch.rx_byte);
        bytes_taken++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_frame_receiver_sum_check: done, errors");
      $finish;
    end
  end

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    foreach (DIRECTED_BYTES[i]) pending_bytes.push_back(DIRECTED_BYTES[i]);
    frame_bytes_queued = 0;
    while (frame_bytes_queued < RANDOM_FRAME_BYTES) begin
      if ($urandom_range(0, 99) < 15) append_noise();
      append_frame();
    end
    total_bytes = pending_bytes.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken != total_bytes) @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb_frame_receiver_sum_check: done, clean");
    end else begin
      $display("tb_frame_receiver_sum_check: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/frsc_pkg.sv
src/frsc_if.sv
src/frame_receiver_sum_check.sv
src/frsc_checker.sv
bench/tb_frame_receiver_sum_check.sv
